/* design/priority_blink_pulse_controller_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the priority blink and pulse controller.
// Each macro expands to one labeled concurrent assertion that reports by
// $error and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BLINK_PULSE_CONTROLLER_ASSERT_SVH
`define PRIORITY_BLINK_PULSE_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/pbpc_pkg.sv */
// ----------------------------------------------------------------------------
// pbpc_pkg
// Shared types and constants of the priority blink and pulse controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pbpc_pkg;

   // Default sizes of the channel table.
   localparam int CHANNELS_DEFAULT   = 8;
   localparam int TIME_WIDTH_DEFAULT = 16;

   // Fixed widths of the request and response fields.
   localparam int LEVEL_W     = 3;
   localparam int CHAN_W      = 3;
   localparam int FIELD_TIME_W = 16;
   localparam int LEVELS_W    = 8;

   // Tick step after reset.
   localparam logic [FIELD_TIME_W-1:0] TICK_STEP_RESET = 16'd1;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_START  = 2'd1,
      OP_STOP   = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   // One request.
   typedef struct packed {
      op_type                  opcode;
      logic [CHAN_W-1:0]       channel;
      logic [LEVEL_W-1:0]      user_level;
      logic [FIELD_TIME_W-1:0] off_time;
      logic [FIELD_TIME_W-1:0] on_time;
      logic [FIELD_TIME_W-1:0] total_time;
   } req_type;

   // One response.
   typedef struct packed {
      logic                accepted;
      logic [LEVELS_W-1:0] levels;
      logic [LEVEL_W-1:0]  channel_owner;
      logic                channel_active;
   } rsp_type;

   // Control from the sequencer to the channel update unit.
   typedef struct packed {
      op_type             op;
      logic [LEVEL_W-1:0] user;
   } unit_ctl_type;

   // Status from the channel update unit back to the sequencer.
   typedef struct packed {
      logic accepted;
      logic write;
   } unit_sts_type;

endpackage

`default_nettype wire

/* design/priority_blink_pulse_controller.sv */
// ----------------------------------------------------------------------------
// priority_blink_pulse_controller
// Table of blinking or pulsing output channels with owner priorities.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge where start is high and busy is low.
//   Opcode tick advances every active channel, start loads one channel and
//   stop clears it; start and stop are refused when the requester ranks
//   below the owner of an active channel.
//   Every request gives exactly one response, shown for one cycle with
//   rsp_strobe high. The receiver cannot stall; it must take it then.
//   The tick step register is written through csr_we and csr_wdata; the user
//   must write it only while the block is idle, the block does not enforce it.
//   Timing: the channel entries live in one RAM and are visited one per
//   cycle by a single shared update unit, pipelined with the RAM read.
//   A tick visits every channel in turn; start, stop and an ignored opcode
//   visit only the addressed channel, and any request other than a tick to
//   a channel beyond the table goes straight to the response.
//   Busy drops in the cycle the response is shown, so a new request can be
//   taken then, but not before the last one is through.
//   Reset is synchronous: all channels inactive and low, tick step one. No
//   clearing pass is needed; an inactive entry is rewritten on start.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_blink_pulse_controller_assert.svh"

module priority_blink_pulse_controller #(
   parameter int CHANNELS   = pbpc_pkg::CHANNELS_DEFAULT,
   parameter int TIME_WIDTH = pbpc_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire pbpc_pkg::req_type                  req_data,
   output logic                                    rsp_strobe,
   output pbpc_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [pbpc_pkg::FIELD_TIME_W-1:0]  csr_wdata
);

   localparam int IW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CW      = TIME_WIDTH + 1;
   localparam int WORD_W  = 3 * TIME_WIDTH + 2 * CW + pbpc_pkg::LEVEL_W;
   localparam logic [IW-1:0] LAST_CH = IW'(CHANNELS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   pbpc_pkg::req_type             req_ff, req_in;
   logic [IW-1:0]                 req_idx_ff, req_idx_in;
   logic                          req_ok_ff, req_ok_in;
   logic [IW-1:0]                 rd_idx_ff, rd_idx_in;
   logic [IW-1:0]                 last_idx_ff, last_idx_in;
   logic                          issue_ff, issue_in;
   logic                          proc_vld_ff, proc_vld_in;
   logic [IW-1:0]                 proc_idx_ff, proc_idx_in;
   logic                          acc_ff, acc_in;
   logic [pbpc_pkg::LEVEL_W-1:0]  owner_q_ff, owner_q_in;
   logic [CHANNELS-1:0]           active_ff, active_in;
   logic [CHANNELS-1:0]           level_ff, level_in;
   logic [CW-1:0]                 step_ff, step_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   pbpc_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          accept;
   logic [63:0]                   new_ch_ext;
   logic                          new_ch_ok;
   logic [63:0]                   csr_ext;
   logic [63:0]                   off_ext;
   logic [63:0]                   on_ext;
   logic [63:0]                   total_ext;
   logic [CHANNELS+7:0]           levels_pad;
   logic                          ram_re;
   logic                          ram_we;
   logic [WORD_W-1:0]             rd_word;
   logic [WORD_W-1:0]             wr_word;
   logic                          proc_last;

   logic [TIME_WIDTH-1:0]         cur_off, cur_on, cur_total;
   logic [CW-1:0]                 cur_phase, cur_elapsed;
   logic [pbpc_pkg::LEVEL_W-1:0]  cur_owner;
   logic [TIME_WIDTH-1:0]         nxt_off, nxt_on, nxt_total;
   logic [CW-1:0]                 nxt_phase, nxt_elapsed;
   logic [pbpc_pkg::LEVEL_W-1:0]  nxt_owner;
   logic                          nxt_active;
   logic                          nxt_level;
   pbpc_pkg::unit_ctl_type        unit_ctl;
   pbpc_pkg::unit_sts_type        unit_sts;

   // Request decode and width adaptation of the time fields.
   assign accept     = start && (state_ff == ST_IDLE);
   assign new_ch_ext = 64'(req_data.channel);
   assign new_ch_ok  = (new_ch_ext < 64'(CHANNELS));
   assign csr_ext    = 64'(csr_wdata);
   assign off_ext    = 64'(req_ff.off_time);
   assign on_ext     = 64'(req_ff.on_time);
   assign total_ext  = 64'(req_ff.total_time);

   // Channel entry storage.
   assign ram_re  = (state_ff == ST_RUN) && issue_ff;
   assign ram_we  = proc_vld_ff && unit_sts.write;
   assign {cur_off, cur_on, cur_total, cur_phase, cur_elapsed, cur_owner} = rd_word;
   assign wr_word = {nxt_off, nxt_on, nxt_total, nxt_phase, nxt_elapsed, nxt_owner};

   pbpc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CHANNELS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (proc_idx_ff),
      .wr_data (wr_word),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_word)
   );

   // Shared channel update unit.
   assign unit_ctl.op   = req_ff.opcode;
   assign unit_ctl.user = req_ff.user_level;

   pbpc_chan_unit #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_chan_unit (
      .ctl         (unit_ctl),
      .req_off     (off_ext[TIME_WIDTH-1:0]),
      .req_on      (on_ext[TIME_WIDTH-1:0]),
      .req_total   (total_ext[TIME_WIDTH-1:0]),
      .step        (step_ff),
      .cur_off     (cur_off),
      .cur_on      (cur_on),
      .cur_total   (cur_total),
      .cur_phase   (cur_phase),
      .cur_elapsed (cur_elapsed),
      .cur_owner   (cur_owner),
      .cur_active  (active_ff[proc_idx_ff]),
      .cur_level   (level_ff[proc_idx_ff]),
      .nxt_off     (nxt_off),
      .nxt_on      (nxt_on),
      .nxt_total   (nxt_total),
      .nxt_phase   (nxt_phase),
      .nxt_elapsed (nxt_elapsed),
      .nxt_owner   (nxt_owner),
      .nxt_active  (nxt_active),
      .nxt_level   (nxt_level),
      .sts         (unit_sts)
   );

   assign proc_last = proc_vld_ff && (proc_idx_ff == last_idx_ff);

   // Sequencer: walks the channels to visit, then builds the response.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      req_idx_in    = req_idx_ff;
      req_ok_in     = req_ok_ff;
      rd_idx_in     = rd_idx_ff;
      last_idx_in   = last_idx_ff;
      issue_in      = issue_ff;
      acc_in        = acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               req_idx_in = new_ch_ext[IW-1:0];
               req_ok_in  = new_ch_ok;
               acc_in     = 1'b0;
               if (req_data.opcode == pbpc_pkg::OP_TICK) begin
                  rd_idx_in   = '0;
                  last_idx_in = LAST_CH;
                  issue_in    = 1'b1;
                  state_in    = ST_RUN;
               end else if (new_ch_ok) begin
                  rd_idx_in   = new_ch_ext[IW-1:0];
                  last_idx_in = new_ch_ext[IW-1:0];
                  issue_in    = 1'b1;
                  state_in    = ST_RUN;
               end else begin
                  state_in    = ST_DONE;
               end
            end
         end
         ST_RUN: begin
            if (issue_ff) begin
               if (rd_idx_ff == last_idx_ff) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
            if (proc_vld_ff && (proc_idx_ff == req_idx_ff)) begin
               acc_in = unit_sts.accepted;
            end
            if (proc_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_strobe_in         = 1'b1;
            rsp_in.accepted       = (req_ff.opcode == pbpc_pkg::OP_TICK) || acc_ff;
            rsp_in.levels         = levels_pad[pbpc_pkg::LEVELS_W-1:0];
            rsp_in.channel_active = req_ok_ff && active_ff[req_idx_ff];
            rsp_in.channel_owner  = (req_ok_ff && active_ff[req_idx_ff]) ? owner_q_ff : '0;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Pipeline of the read data into the update unit.
   assign proc_vld_in = ram_re;
   assign proc_idx_in = rd_idx_ff;

   // Owner of the addressed channel after this request.
   assign owner_q_in = (proc_vld_ff && (proc_idx_ff == req_idx_ff)) ? nxt_owner : owner_q_ff;

   // Per-channel active and level flags, updated by the unit.
   always_comb begin
      active_in = active_ff;
      level_in  = level_ff;
      if (ram_we) begin
         active_in[proc_idx_ff] = nxt_active;
         level_in[proc_idx_ff]  = nxt_level;
      end
   end

   assign levels_pad = {8'b0, level_ff};

   // Tick step register.
   assign step_in = csr_we ? csr_ext[CW-1:0] : step_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         proc_vld_ff   <= 1'b0;
         active_ff     <= '0;
         level_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         step_ff       <= CW'(pbpc_pkg::TICK_STEP_RESET);
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         proc_vld_ff   <= proc_vld_in;
         active_ff     <= active_in;
         level_ff      <= level_in;
         rsp_strobe_ff <= rsp_strobe_in;
         step_ff       <= step_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      req_idx_ff  <= req_idx_in;
      req_ok_ff   <= req_ok_in;
      rd_idx_ff   <= rd_idx_in;
      last_idx_ff <= last_idx_in;
      proc_idx_ff <= proc_idx_in;
      acc_ff      <= acc_in;
      owner_q_ff  <= owner_q_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Assertions.
   `PBPC_ASSERT_NOW(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `PBPC_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_strobe, !busy, "response while busy")
   `PBPC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy not raised after request")
   `PBPC_ASSERT_NEXT(a_done_rsp, clock, reset, state_ff == ST_DONE, rsp_strobe, "missing response")
   `PBPC_ASSERT_NOW(a_proc_run, clock, reset, proc_vld_ff, state_ff == ST_RUN, "update outside run")
   `PBPC_ASSERT_NOW(a_issue_run, clock, reset, issue_ff, state_ff == ST_RUN, "read outside run")

endmodule

`default_nettype wire

/* design/pbpc_ram.sv */
// ----------------------------------------------------------------------------
// pbpc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                           clock,
   input  wire logic                                           wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                               wr_data,
   input  wire logic                                           rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/pbpc_chan_unit.sv */
// ----------------------------------------------------------------------------
// pbpc_chan_unit
// Shared update unit: computes the next state of one channel entry for a
// tick, start, stop or ignored request.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpc_chan_unit #(
   parameter int TIME_WIDTH = pbpc_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire pbpc_pkg::unit_ctl_type     ctl,
   input  wire logic [TIME_WIDTH-1:0]      req_off,
   input  wire logic [TIME_WIDTH-1:0]      req_on,
   input  wire logic [TIME_WIDTH-1:0]      req_total,
   input  wire logic [TIME_WIDTH:0]        step,
   input  wire logic [TIME_WIDTH-1:0]      cur_off,
   input  wire logic [TIME_WIDTH-1:0]      cur_on,
   input  wire logic [TIME_WIDTH-1:0]      cur_total,
   input  wire logic [TIME_WIDTH:0]        cur_phase,
   input  wire logic [TIME_WIDTH:0]        cur_elapsed,
   input  wire logic [pbpc_pkg::LEVEL_W-1:0] cur_owner,
   input  wire logic                       cur_active,
   input  wire logic                       cur_level,
   output logic      [TIME_WIDTH-1:0]      nxt_off,
   output logic      [TIME_WIDTH-1:0]      nxt_on,
   output logic      [TIME_WIDTH-1:0]      nxt_total,
   output logic      [TIME_WIDTH:0]        nxt_phase,
   output logic      [TIME_WIDTH:0]        nxt_elapsed,
   output logic      [pbpc_pkg::LEVEL_W-1:0] nxt_owner,
   output logic                            nxt_active,
   output logic                            nxt_level,
   output pbpc_pkg::unit_sts_type          sts
);

   logic                  total_nz;
   logic                  elapsed_lt;
   logic                  on_done;
   logic                  off_done;
   logic                  restart;
   logic [TIME_WIDTH:0]   elapsed_sum;
   logic [TIME_WIDTH:0]   phase_base;
   logic [TIME_WIDTH:0]   phase_sum;

   // Counter compares and the two adders of the unit.
   assign total_nz    = (cur_total != '0);
   assign elapsed_lt  = (cur_elapsed < {1'b0, cur_total});
   assign on_done     = (cur_phase >= {1'b0, cur_on});
   assign off_done    = (cur_phase >= {1'b0, cur_off});
   assign restart     = cur_level ? on_done : off_done;
   assign elapsed_sum = cur_elapsed + step;
   assign phase_base  = restart ? '0 : cur_phase;
   assign phase_sum   = phase_base + step;

   // Next entry by operation.
   always_comb begin
      nxt_off      = cur_off;
      nxt_on       = cur_on;
      nxt_total    = cur_total;
      nxt_phase    = cur_phase;
      nxt_elapsed  = cur_elapsed;
      nxt_owner    = cur_owner;
      nxt_active   = cur_active;
      nxt_level    = cur_level;
      sts.accepted = 1'b0;
      sts.write    = 1'b0;
      case (ctl.op)
         pbpc_pkg::OP_TICK: begin
            if (cur_active) begin
               sts.accepted = 1'b1;
               sts.write    = 1'b1;
               if (cur_off == '0) begin
                  // Hold mode: output stays on while the on time is nonzero.
                  if (cur_on != '0) begin
                     nxt_level = 1'b1;
                  end
                  if (total_nz) begin
                     if (elapsed_lt) begin
                        nxt_elapsed = elapsed_sum;
                     end else begin
                        nxt_level   = 1'b0;
                        nxt_elapsed = '0;
                        nxt_owner   = '0;
                        nxt_active  = 1'b0;
                     end
                  end
               end else if (total_nz && !elapsed_lt) begin
                  // Blink mode, total reached: the channel ends.
                  nxt_level   = 1'b0;
                  nxt_elapsed = '0;
                  nxt_owner   = '0;
                  nxt_active  = 1'b0;
                  nxt_phase   = '0;
               end else begin
                  // Blink mode: toggle the phase when its length is reached.
                  if (total_nz) begin
                     nxt_elapsed = elapsed_sum;
                  end
                  if (restart) begin
                     nxt_level = cur_level ? 1'b0 : (cur_on != '0);
                  end
                  nxt_phase = phase_sum;
               end
            end
         end
         pbpc_pkg::OP_START: begin
            if (!(cur_active && (ctl.user < cur_owner))) begin
               sts.accepted = 1'b1;
               sts.write    = 1'b1;
               nxt_off      = req_off;
               nxt_on       = req_on;
               nxt_total    = req_total;
               nxt_phase    = '0;
               nxt_elapsed  = '0;
               nxt_owner    = ctl.user;
               nxt_level    = (req_on != '0);
               nxt_active   = 1'b1;
            end
         end
         pbpc_pkg::OP_STOP: begin
            if (!cur_active) begin
               sts.accepted = 1'b1;
            end else if (ctl.user >= cur_owner) begin
               sts.accepted = 1'b1;
               sts.write    = 1'b1;
               nxt_off      = '0;
               nxt_on       = '0;
               nxt_total    = '0;
               nxt_phase    = '0;
               nxt_elapsed  = '0;
               nxt_owner    = '0;
               nxt_level    = 1'b0;
               nxt_active   = 1'b0;
            end
         end
         default: begin
            sts.accepted = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* bench/priority_blink_pulse_controller_checker.sv */
// ----------------------------------------------------------------------------
// Priority blink and pulse controller response checker
// Watches the request, response and register ports of the controller, keeps
// its own copy of the channel table and the tick step, predicts the response
// of every accepted request and compares each response with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------

module priority_blink_pulse_controller_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  pbpc_pkg::req_type                 req_data,
   input  logic                              rsp_strobe,
   input  pbpc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [pbpc_pkg::FIELD_TIME_W-1:0] csr_wdata,
   output int                                error_count,
   output int                                pending_count,
   output int                                checked_count,
   output int                                refused_count
);

   localparam int NCHAN = pbpc_pkg::CHANNELS_DEFAULT;
   localparam int TW = pbpc_pkg::FIELD_TIME_W;
   localparam int MAX_REPORTS = 10;

   // Shadow copy of the channel table and the tick step.
   logic [TW-1:0]                step_size;
   logic [TW-1:0]                ch_off     [NCHAN];
   logic [TW-1:0]                ch_on      [NCHAN];
   logic [TW-1:0]                ch_total   [NCHAN];
   logic [TW:0]                  ch_phase   [NCHAN];
   logic [TW:0]                  ch_elapsed [NCHAN];
   logic                         ch_level   [NCHAN];
   logic                         ch_active  [NCHAN];
   logic [pbpc_pkg::LEVEL_W-1:0] ch_owner   [NCHAN];

   // Responses predicted but not yet seen, oldest first.
   pbpc_pkg::rsp_type status_queue[$];

   function automatic void clear_table();
      step_size = pbpc_pkg::TICK_STEP_RESET;
      for (int c = 0; c < NCHAN; c++) begin
         ch_off[c]     = '0;
         ch_on[c]      = '0;
         ch_total[c]   = '0;
         ch_phase[c]   = '0;
         ch_elapsed[c] = '0;
         ch_level[c]   = 1'b0;
         ch_active[c]  = 1'b0;
         ch_owner[c]   = '0;
      end
   endfunction

   // A finished or stopped channel goes low and gives up its owner.
   function automatic void release_channel(input int c);
      ch_level[c]   = 1'b0;
      ch_elapsed[c] = '0;
      ch_owner[c]   = '0;
      ch_active[c]  = 1'b0;
   endfunction

   // One tick of one active channel.
   function automatic void advance_channel(input int c);
      if (ch_off[c] == '0) begin
         // Hold mode: the output stays on unless the on time is zero.
         if (!ch_level[c] && ch_on[c] != '0)
            ch_level[c] = 1'b1;
         if (ch_total[c] != '0) begin
            if (ch_elapsed[c] < ch_total[c])
               ch_elapsed[c] = ch_elapsed[c] + step_size;
            else
               release_channel(c);
         end
         return;
      end

      // Blink mode: the total time is checked before the phase advances.
      if (ch_total[c] != '0) begin
         if (ch_elapsed[c] < ch_total[c]) begin
            ch_elapsed[c] = ch_elapsed[c] + step_size;
         end else begin
            release_channel(c);
            ch_phase[c] = '0;
            return;
         end
      end

      if (ch_level[c]) begin
         if (ch_phase[c] >= ch_on[c]) begin
            ch_level[c] = 1'b0;
            ch_phase[c] = '0;
         end
      end else if (ch_phase[c] >= ch_off[c]) begin
         if (ch_on[c] != '0)
            ch_level[c] = 1'b1;
         ch_phase[c] = '0;
      end
      ch_phase[c] = ch_phase[c] + step_size;
   endfunction

   // Applies one request to the shadow table and returns its response.
   function automatic pbpc_pkg::rsp_type predict_status(input pbpc_pkg::req_type r);
      pbpc_pkg::rsp_type s;
      int                ch;
      logic              ok;

      ch = int'(r.channel);
      ok = 1'b0;
      case (r.opcode)
         pbpc_pkg::OP_TICK: begin
            for (int c = 0; c < NCHAN; c++)
               if (ch_active[c])
                  advance_channel(c);
            ok = 1'b1;
         end
         pbpc_pkg::OP_START: begin
            if (!(ch_active[ch] && r.user_level < ch_owner[ch])) begin
               ch_off[ch]     = r.off_time;
               ch_on[ch]      = r.on_time;
               ch_total[ch]   = r.total_time;
               ch_phase[ch]   = '0;
               ch_elapsed[ch] = '0;
               ch_owner[ch]   = r.user_level;
               ch_level[ch]   = (r.on_time != '0);
               ch_active[ch]  = 1'b1;
               ok = 1'b1;
            end else begin
               refused_count++;
            end
         end
         pbpc_pkg::OP_STOP: begin
            if (!ch_active[ch]) begin
               ok = 1'b1;
            end else if (r.user_level >= ch_owner[ch]) begin
               ch_off[ch]   = '0;
               ch_on[ch]    = '0;
               ch_total[ch] = '0;
               ch_phase[ch] = '0;
               release_channel(ch);
               ok = 1'b1;
            end else begin
               refused_count++;
            end
         end
         default: ;
      endcase

      s.accepted = ok;
      for (int c = 0; c < pbpc_pkg::LEVELS_W; c++)
         s.levels[c] = (c < NCHAN) ? ch_level[c] : 1'b0;
      s.channel_owner  = ch_owner[ch];
      s.channel_active = ch_active[ch];
      return s;
   endfunction

   // Register writes, response checks and new predictions, all taken at the
   // clock edge that accepts them.
   always @(posedge clock) begin
      pbpc_pkg::rsp_type want;
      if (reset) begin
         clear_table();
         status_queue.delete();
      end else begin
         if (csr_we)
            step_size = csr_wdata;

         if (rsp_strobe) begin
            if (status_queue.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"Response with no request outstanding: ",
                            "acc=%0b levels=%02h owner=%0d active=%0b"},
                           rsp_data.accepted, rsp_data.levels,
                           rsp_data.channel_owner, rsp_data.channel_active);
            end else begin
               want = status_queue.pop_front();
               checked_count++;
               if (rsp_data.accepted !== want.accepted ||
                   rsp_data.levels !== want.levels ||
                   rsp_data.channel_owner !== want.channel_owner ||
                   rsp_data.channel_active !== want.channel_active) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display({"Response %0d differs: expected acc=%0b levels=%02h owner=%0d ",
                               "active=%0b, got acc=%0b levels=%02h owner=%0d active=%0b"},
                              checked_count, want.accepted, want.levels,
                              want.channel_owner, want.channel_active,
                              rsp_data.accepted, rsp_data.levels,
                              rsp_data.channel_owner, rsp_data.channel_active);
               end
            end
         end

         if (start && !busy)
            status_queue.push_back(predict_status(req_data));
      end
      pending_count = status_queue.size();
   end

endmodule

/* bench/priority_blink_pulse_controller_test.sv */
// ----------------------------------------------------------------------------
// Priority blink and pulse controller testbench
// Drives directed and random tick, start, stop and unused-opcode requests
// under several tick step settings, with random gaps between requests, and
// lets the response checker predict and compare every response.
// ----------------------------------------------------------------------------

module priority_blink_pulse_controller_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TW = pbpc_pkg::FIELD_TIME_W;
   localparam int CW = pbpc_pkg::CHAN_W;
   localparam int LW = pbpc_pkg::LEVEL_W;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   pbpc_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   pbpc_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic [TW-1:0]     csr_wdata = '0;

   int error_count;
   int pending_count;
   int checked_count;
   int refused_count;
   int cycle_count = 0;

   // Request statistics for the closing summary.
   int tick_count = 0;
   int start_count = 0;
   int stop_count = 0;
   int ignore_count = 0;
   int setting_count = 0;
   bit gaps_on = 1'b1;

   priority_blink_pulse_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   priority_blink_pulse_controller_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .refused_count (refused_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_count);
         $display("Verification failed");
         $finish;
      end
   end

   // Presents one request, sometimes after a random gap, and holds it until accepted.
   task automatic issue(input pbpc_pkg::req_type r);
      if (gaps_on && $urandom_range(99) < 36) begin
         start <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < 36);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      case (r.opcode)
         pbpc_pkg::OP_TICK:  tick_count++;
         pbpc_pkg::OP_START: start_count++;
         pbpc_pkg::OP_STOP:  stop_count++;
         default:            ignore_count++;
      endcase
   endtask

   task automatic issue_fields(input pbpc_pkg::op_type op, input int ch, input int user,
                               input int off_t, input int on_t, input int total_t);
      pbpc_pkg::req_type r;
      r.opcode     = op;
      r.channel    = CW'(ch);
      r.user_level = LW'(user);
      r.off_time   = TW'(off_t);
      r.on_time    = TW'(on_t);
      r.total_time = TW'(total_t);
      issue(r);
   endtask

   // Stops sending until every outstanding response has come back.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0 || busy)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_step(input logic [TW-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      setting_count++;
   endtask

   // Mostly short times so that phases and totals run out, with the
   // extremes and full-range values mixed in.
   function automatic logic [TW-1:0] pick_time();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55)
         return TW'($urandom_range(12));
      else if (roll < 72)
         return '0;
      else if (roll < 80)
         return '1;
      else if (roll < 92)
         return TW'($urandom_range(65535));
      else
         return TW'($urandom_range(100, 13));
   endfunction

   task automatic run_random(input int count);
      pbpc_pkg::req_type r;
      int                roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 46)
            r.opcode = pbpc_pkg::OP_TICK;
         else if (roll < 76)
            r.opcode = pbpc_pkg::OP_START;
         else if (roll < 93)
            r.opcode = pbpc_pkg::OP_STOP;
         else
            r.opcode = pbpc_pkg::OP_IGNORE;
         r.channel    = CW'($urandom_range(7));
         r.user_level = LW'($urandom_range(7));
         r.off_time   = pick_time();
         r.on_time    = pick_time();
         r.total_time = pick_time();
         issue(r);
         // Now and then let the block run dry before going on.
         if ($urandom_range(49) == 0)
            drain();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at the reset tick step of one.
      issue_fields(pbpc_pkg::OP_TICK, 0, 0, 0, 0, 0);
      // Hold on forever, blink with a total, low with a total, extremes,
      // and a blink with zero on time.
      issue_fields(pbpc_pkg::OP_START, 0, 3, 0, 5, 0);
      issue_fields(pbpc_pkg::OP_START, 1, 2, 2, 3, 12);
      issue_fields(pbpc_pkg::OP_START, 2, 7, 0, 0, 3);
      issue_fields(pbpc_pkg::OP_START, 7, 7, 65535, 65535, 65535);
      issue_fields(pbpc_pkg::OP_START, 3, 0, 1, 0, 0);
      repeat (6) issue_fields(pbpc_pkg::OP_TICK, 5, 4, 65535, 0, 65535);
      // Lower rank is refused, equal rank is taken.
      issue_fields(pbpc_pkg::OP_START, 0, 2, 9, 9, 9);
      issue_fields(pbpc_pkg::OP_START, 0, 3, 1, 1, 4);
      issue_fields(pbpc_pkg::OP_STOP, 1, 1, 0, 0, 0);
      issue_fields(pbpc_pkg::OP_STOP, 1, 2, 0, 0, 0);
      // Stop of an idle channel and the unused opcode.
      issue_fields(pbpc_pkg::OP_STOP, 4, 0, 0, 0, 0);
      issue_fields(pbpc_pkg::OP_IGNORE, 7, 7, 65535, 65535, 65535);
      repeat (6) issue_fields(pbpc_pkg::OP_TICK, 6, 0, 0, 65535, 0);
      issue_fields(pbpc_pkg::OP_STOP, 7, 7, 0, 0, 0);
      issue_fields(pbpc_pkg::OP_START, 5, 0, 0, 0, 0);
      issue_fields(pbpc_pkg::OP_TICK, 0, 0, 0, 0, 0);
      drain();

      // Random phases under several tick steps, extremes included.
      write_step(16'd1);
      run_random(230);
      drain();
      write_step(16'hFFFF);
      run_random(120);
      drain();
      write_step(16'd0);
      run_random(70);
      drain();
      write_step(16'($urandom_range(40, 2)));
      gaps_on = 1'b0;
      run_random(130);
      gaps_on = 1'b1;
      run_random(130);
      drain();
      write_step(16'($urandom_range(65535, 1)));
      run_random(100);
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("Sent %0d requests: %0d ticks, %0d starts, %0d stops, %0d unused opcodes.",
               tick_count + start_count + stop_count + ignore_count,
               tick_count, start_count, stop_count, ignore_count);
      $display("Checked %0d responses over %0d tick steps; %0d starts or stops refused.",
               checked_count, setting_count + 1, refused_count);
      if (error_count == 0 && pending_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
